[sv/srls_pkg.sv]
// Shared types, constants and pixel formatting for the serpentine LED serializer.
package srls_pkg;

  localparam int PIXEL_COUNT = 64;
  localparam int ROW_LENGTH  = 8;

  localparam int ADDR_W  = $clog2(PIXEL_COUNT);
  localparam int IDX_W   = $clog2(PIXEL_COUNT + ROW_LENGTH);
  localparam int COL_W   = $clog2(ROW_LENGTH);
  localparam int COLOR_W = 16;
  localparam int WORD_W  = 24;
  localparam int TICK_W  = 8;
  localparam int BIT_W   = 5;
  localparam int SHIFT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int BITS_PER_PIXEL = 24;

  localparam logic [COLOR_W-1:0] RED_MASK   = 16'hF800;
  localparam logic [COLOR_W-1:0] GREEN_MASK = 16'h07E0;
  localparam logic [COLOR_W-1:0] BLUE_MASK  = 16'h001F;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ONE_HIGH   = 3'd1,
    REG_ONE_LOW    = 3'd2,
    REG_ZERO_HIGH  = 3'd3,
    REG_ZERO_LOW   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOAD = 2'd1,
    ST_SEND = 2'd2
  } state_t;

  typedef struct packed {
    logic start;
    logic adv;
  } scan_ctrl_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    at_least_one = (v == '0) ? TICK_W'(1) : v;
  endfunction

  // RGB565 -> dimmed GRB888
  function automatic logic [WORD_W-1:0] pixel_word(input logic [COLOR_W-1:0] c,
                                                   input logic [SHIFT_W-1:0] s);
    logic [COLOR_W-1:0] rm;
    logic [COLOR_W-1:0] gm;
    logic [COLOR_W-1:0] bm;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    rm = c & RED_MASK;
    gm = c & GREEN_MASK;
    bm = c & BLUE_MASK;
    r = rm[15:8] >> s;
    g = gm[10:3] >> s;
    b = {bm[4:0], 3'b000} >> s;
    pixel_word = {g, r, b};
  endfunction

endpackage

[sv/serpentine_rgb_led_serializer.sv]
// Top level: frame RAM, serpentine scan and one-wire bit timing.
// Every request returns one result. Requests are taken one per cycle while
// out_stall does not hold a result, except that a start request and the tick
// that ends the last bit of a pixel (when more pixels follow) hold in_stall
// high for one extra cycle while the next pixel is read from the frame RAM,
// whose read data is registered. A full frame therefore costs one tick request
// per pulse tick. Pixel writes and starts while a frame is going out are
// dropped; configuration is taken at any time through cfg_ready.
module serpentine_rgb_led_serializer import srls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [5:0]           in_pixel_index,
  input  logic [COLOR_W-1:0]   in_color,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_line_level,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  state_t             state_r, state_nxt;
  logic               high_r, high_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [WORD_W-1:0]  shift_r, shift_nxt;
  logic [SHIFT_W-1:0] bright_r;
  logic [TICK_W-1:0]  one_high_r, one_low_r, zero_high_r, zero_low_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_level_r, out_level_nxt;
  logic               out_busy_r, out_busy_nxt;
  logic               out_done_r, out_done_nxt;

  logic               in_acc;
  logic               sending;
  logic               done;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               scan_in_range;
  logic               scan_last;
  scan_ctrl_t         scan_ctrl;
  logic [TICK_W-1:0]  dec;
  logic [WORD_W-1:0]  shifted;
  logic [WORD_W-1:0]  word;

  assign in_stall  = (state_r == ST_LOAD) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign sending   = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  srls_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PIXEL_COUNT)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(in_pixel_index)),
    .wdata(in_color),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  srls_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (scan_ctrl),
    .rd_addr (rd_addr),
    .in_range(scan_in_range),
    .last    (scan_last)
  );

  always_comb begin
    state_nxt       = state_r;
    high_nxt        = high_r;
    tick_nxt        = tick_r;
    bit_nxt         = bit_r;
    shift_nxt       = shift_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    scan_ctrl.start = 1'b0;
    scan_ctrl.adv   = 1'b0;
    done            = 1'b0;
    dec             = tick_r - TICK_W'(1);
    shifted         = shift_r << 1;
    word            = scan_in_range ? pixel_word(rd_data, bright_r) : '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == OP_WRITE &&
            32'(in_pixel_index) < 32'(PIXEL_COUNT)) begin
          ram_we = 1'b1;
        end else if (in_acc && in_op == OP_START) begin
          scan_ctrl.start = 1'b1;
          ram_re          = 1'b1;
          bit_nxt         = '0;
          state_nxt       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        shift_nxt = word;
        high_nxt  = 1'b1;
        tick_nxt  = at_least_one(word[WORD_W-1] ? one_high_r : zero_high_r);
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (in_acc && in_op == OP_TICK) begin
          tick_nxt = dec;
          if (dec == '0) begin
            if (high_r) begin
              high_nxt = 1'b0;
              tick_nxt = at_least_one(shift_r[WORD_W-1] ? one_low_r : zero_low_r);
            end else begin
              shift_nxt = shifted;
              if (bit_r == BIT_W'(BITS_PER_PIXEL - 1)) begin
                bit_nxt = '0;
                if (scan_last) begin
                  shift_nxt = '0;
                  done      = 1'b1;
                  state_nxt = ST_IDLE;
                end else begin
                  scan_ctrl.adv = 1'b1;
                  ram_re        = 1'b1;
                  state_nxt     = ST_LOAD;
                end
              end else begin
                bit_nxt  = bit_r + BIT_W'(1);
                high_nxt = 1'b1;
                tick_nxt = at_least_one(shifted[WORD_W-1] ? one_high_r : zero_high_r);
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_busy_nxt  = out_busy_r;
    out_done_nxt  = out_done_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = sending && high_r;
      out_busy_nxt  = (state_nxt != ST_IDLE);
      out_done_nxt  = done;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      high_r      <= 1'b0;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      high_r      <= high_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r <= out_level_nxt;
    out_busy_r  <= out_busy_nxt;
    out_done_r  <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= SHIFT_W'(4);
      one_high_r  <= TICK_W'(25);
      one_low_r   <= TICK_W'(1);
      zero_high_r <= TICK_W'(1);
      zero_low_r  <= TICK_W'(15);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: bright_r    <= cfg_data[SHIFT_W-1:0];
        REG_ONE_HIGH:   one_high_r  <= cfg_data;
        REG_ONE_LOW:    one_low_r   <= cfg_data;
        REG_ZERO_HIGH:  zero_high_r <= cfg_data;
        REG_ZERO_LOW:   zero_low_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_level_r;
  assign out_busy_res   = out_busy_r;
  assign out_frame_done = out_done_r;

endmodule

[sv/srls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/srls_scan.sv]
// Serpentine scan counter: pixel position to frame address.
module srls_scan import srls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctrl_t        ctrl,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              in_range,
  output logic              last
);

  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic              odd_r, odd_nxt;
  logic              in_range_r, in_range_nxt;
  logic [IDX_W-1:0]  idx;

  always_comb begin
    pos_nxt  = pos_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    odd_nxt  = odd_r;
    if (ctrl.start) begin
      pos_nxt  = '0;
      col_nxt  = '0;
      base_nxt = '0;
      odd_nxt  = 1'b0;
    end else if (ctrl.adv) begin
      pos_nxt = pos_r + ADDR_W'(1);
      if (col_r == COL_W'(ROW_LENGTH - 1)) begin
        col_nxt  = '0;
        base_nxt = base_r + IDX_W'(ROW_LENGTH);
        odd_nxt  = !odd_r;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    // even rows go out reversed
    if (odd_nxt) begin
      idx = base_nxt + IDX_W'(col_nxt);
    end else begin
      idx = base_nxt + IDX_W'(ROW_LENGTH - 1) - IDX_W'(col_nxt);
    end
    in_range_nxt = in_range_r;
    if (ctrl.start || ctrl.adv) begin
      in_range_nxt = (idx < IDX_W'(PIXEL_COUNT));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      col_r      <= '0;
      base_r     <= '0;
      odd_r      <= 1'b0;
      in_range_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      col_r      <= col_nxt;
      base_r     <= base_nxt;
      odd_r      <= odd_nxt;
      in_range_r <= in_range_nxt;
    end
  end

  assign rd_addr  = idx[ADDR_W-1:0];
  assign in_range = in_range_r;
  assign last     = (pos_r == ADDR_W'(PIXEL_COUNT - 1));

endmodule

[sv/srls_checker.sv]
// Port-level checker for the serpentine LED serializer, bound to the top level.
module srls_checker import srls_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [1:0]           in_op,
  input logic [5:0]           in_pixel_index,
  input logic [COLOR_W-1:0]   in_color,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_line_level,
  input logic                 out_busy_res,
  input logic                 out_frame_done,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [7:0]           cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_level) &&
      $stable(out_busy_res) && $stable(out_frame_done))
    else $error("stalled result changed");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res && !out_line_level)
    else $error("frame done while still busy or line high");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_line_level)
    else $error("line high with no frame going out");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_START && !out_stall |=> out_valid && out_busy_res)
    else $error("start request did not report busy");

endmodule

bind serpentine_rgb_led_serializer srls_checker u_srls_checker (.*);

[verif/led_frame_checker.sv]
// Checker for the serpentine LED serializer: tracks config and requests, predicts, compares.
module led_frame_checker import srls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [5:0]           in_pixel_index,
  input  logic [COLOR_W-1:0]   in_color,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_line_level,
  input  logic                 out_busy_res,
  input  logic                 out_frame_done,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output logic                 frame_active
);

  typedef struct packed {
    logic line_level;
    logic busy;
    logic done;
  } line_state_t;

  localparam int MAX_PRINTS = 100;

  logic [SHIFT_W-1:0] dim_shift;
  logic [TICK_W-1:0]  one_hi, one_lo, zero_hi, zero_lo;

  logic [COLOR_W-1:0] frame_mem [PIXEL_COUNT];
  logic               streaming;
  logic               high_half;
  int unsigned        pixel_slot;
  int unsigned        bit_slot;
  logic [TICK_W-1:0]  tick_left;
  logic [WORD_W-1:0]  grb_word;

  line_state_t line_expect_q [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    frame_active = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTS)
      $display("%0t mismatch: %s", $realtime, msg);
    fail_count = fail_count + 1;
  endtask

  function automatic logic [TICK_W-1:0] hold_ticks(logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // dimmed GRB word for a position in serpentine scan order
  function automatic logic [WORD_W-1:0] grb_for_slot(int unsigned slot);
    int unsigned row, col, addr;
    logic [COLOR_W-1:0] c;
    logic [7:0] r, g, b;
    row  = slot / ROW_LENGTH;
    col  = slot % ROW_LENGTH;
    addr = (row % 2 == 0) ? row * ROW_LENGTH + (ROW_LENGTH - 1 - col) : slot;
    c = (addr < PIXEL_COUNT) ? frame_mem[addr] : '0;
    r = {c[15:11], 3'b000} >> dim_shift;
    g = {c[10:5], 2'b00} >> dim_shift;
    b = {c[4:0], 3'b000} >> dim_shift;
    return {g, r, b};
  endfunction

  function automatic void open_bit();
    high_half = 1'b1;
    tick_left = hold_ticks(grb_word[WORD_W-1] ? one_hi : zero_hi);
  endfunction

  function automatic line_state_t next_line_state(logic [1:0] op, logic [5:0] idx,
                                                  logic [COLOR_W-1:0] col);
    line_state_t res;
    res.line_level = streaming && high_half;
    res.done = 1'b0;
    case (op)
      OP_WRITE: begin
        if (!streaming && idx < PIXEL_COUNT)
          frame_mem[idx] = col;
      end
      OP_START: begin
        if (!streaming) begin
          streaming  = 1'b1;
          pixel_slot = 0;
          bit_slot   = 0;
          grb_word   = grb_for_slot(0);
          open_bit();
        end
      end
      OP_TICK: begin
        if (streaming) begin
          tick_left = tick_left - TICK_W'(1);
          if (tick_left == '0) begin
            if (high_half) begin
              high_half = 1'b0;
              tick_left = hold_ticks(grb_word[WORD_W-1] ? one_lo : zero_lo);
            end else begin
              grb_word = grb_word << 1;
              bit_slot++;
              if (bit_slot >= BITS_PER_PIXEL) begin
                bit_slot = 0;
                pixel_slot++;
                if (pixel_slot >= PIXEL_COUNT) begin
                  streaming  = 1'b0;
                  pixel_slot = 0;
                  grb_word   = '0;
                  res.done   = 1'b1;
                end else begin
                  grb_word = grb_for_slot(pixel_slot);
                end
              end
              if (streaming)
                open_bit();
            end
          end
        end
      end
      default: ;
    endcase
    res.busy = streaming;
    return res;
  endfunction

  always @(posedge clk) begin
    line_state_t want;
    if (!rst_n) begin
      dim_shift  = SHIFT_W'(4);
      one_hi     = TICK_W'(25);
      one_lo     = TICK_W'(1);
      zero_hi    = TICK_W'(1);
      zero_lo    = TICK_W'(15);
      streaming  = 1'b0;
      high_half  = 1'b0;
      pixel_slot = 0;
      bit_slot   = 0;
      tick_left  = '0;
      grb_word   = '0;
      line_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BRIGHTNESS: dim_shift = cfg_data[SHIFT_W-1:0];
          REG_ONE_HIGH:   one_hi    = cfg_data;
          REG_ONE_LOW:    one_lo    = cfg_data;
          REG_ZERO_HIGH:  zero_hi   = cfg_data;
          REG_ZERO_LOW:   zero_lo   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        line_expect_q.push_back(next_line_state(in_op, in_pixel_index, in_color));
      if (out_valid && !out_stall) begin
        if (line_expect_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = line_expect_q.pop_front();
          if (out_line_level !== want.line_level)
            report_mismatch($sformatf("line_level got %b want %b", out_line_level,
                                      want.line_level));
          if (out_busy_res !== want.busy)
            report_mismatch($sformatf("busy_res got %b want %b", out_busy_res, want.busy));
          if (out_frame_done !== want.done)
            report_mismatch($sformatf("frame_done got %b want %b", out_frame_done,
                                      want.done));
        end
      end
    end
    pending      <= line_expect_q.size();
    frame_active <= streaming;
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the serpentine LED serializer: clock, reset, stimulus and verdict.
module tb_top;
  import srls_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CFG_LAST  = (1 << CFG_IDX_W) - 1;
  localparam int HOLD_LEN  = 400;
  localparam int RETIME_LEN = 200;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_op          = '0;
  logic [5:0]           in_pixel_index = '0;
  logic [COLOR_W-1:0]   in_color       = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_line_level;
  logic                 out_busy_res;
  logic                 out_frame_done;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [7:0]           cfg_data       = '0;

  int   fail_count;
  int   pending;
  logic frame_active;

  int send_pct  = 0;
  int recv_pct  = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit busy_before;

  serpentine_rgb_led_serializer i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_op, .in_pixel_index, .in_color,
    .out_valid, .out_stall, .out_line_level, .out_busy_res, .out_frame_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  led_frame_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_op, .in_pixel_index, .in_color,
    .out_valid, .out_stall, .out_line_level, .out_busy_res, .out_frame_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .frame_active
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random stall, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // busy_before: frame state just before the accepted request
  task automatic send_req(logic [1:0] op, logic [5:0] idx, logic [COLOR_W-1:0] col);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_pixel_index <= idx;
    in_color       <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    busy_before = frame_active;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_timing(logic [SHIFT_W-1:0] shift, logic [7:0] oh, logic [7:0] ol,
                            logic [7:0] zh, logic [7:0] zl);
    drain();
    repeat (4) @(posedge clk);
    reg_write(REG_BRIGHTNESS, {5'($urandom), shift});
    reg_write(REG_ONE_HIGH, oh);
    reg_write(REG_ONE_LOW, ol);
    reg_write(REG_ZERO_HIGH, zh);
    reg_write(REG_ZERO_LOW, zl);
    reg_write(CFG_IDX_W'($urandom_range(REG_ZERO_LOW + 1, CFG_LAST)), 8'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] short_ticks();
    return 8'($urandom_range(0, 1));
  endfunction

  task automatic fill_frame(bit all_white);
    for (int i = 0; i < PIXEL_COUNT; i++)
      send_req(OP_WRITE, 6'(i), all_white ? '1 : COLOR_W'($urandom));
  endtask

  // start, dropped busy requests, then ticks until the frame has ended;
  // long counts for a stretch in the middle, idling changes on the way
  task automatic run_frame(int hold_at, int retime_at, int swap_at, int quiet_at);
    int n;
    n = 0;
    send_req(OP_START, 6'($urandom), COLOR_W'($urandom));
    send_req(OP_START, 6'($urandom), COLOR_W'($urandom));
    send_req(OP_WRITE, 6'($urandom), COLOR_W'($urandom));
    do begin
      if (n == hold_at)
        hold_reqs <= hold_reqs + 1;
      if (n == retime_at)
        set_timing(SHIFT_W'($urandom), 8'd255, 8'd1, 8'd1, 8'd15);
      if (n == retime_at + RETIME_LEN)
        set_timing(SHIFT_W'($urandom), short_ticks(), short_ticks(), short_ticks(),
                   short_ticks());
      if (n == swap_at) begin
        send_pct = 53;
        recv_pct = 23;
      end
      if (n == quiet_at) begin
        send_pct = 0;
        recv_pct = 0;
      end
      if ($urandom_range(99) < 3)
        send_req(($urandom_range(1) == 0) ? OP_WRITE : OP_UNUSED, 6'($urandom),
                 COLOR_W'($urandom));
      else
        send_req(OP_TICK, 6'($urandom), COLOR_W'($urandom));
      n++;
    end while (busy_before);
  endtask

  task automatic random_round();
    int pick;
    repeat (60) begin
      pick = $urandom_range(99);
      if (pick < 70)
        send_req(OP_WRITE, 6'($urandom), COLOR_W'($urandom));
      else if (pick < 88)
        send_req(OP_TICK, 6'($urandom), COLOR_W'($urandom));
      else
        send_req(OP_UNUSED, 6'($urandom), COLOR_W'($urandom));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_pct = 23;
    recv_pct = 53;
    send_req(OP_TICK, '0, '0);
    send_req(OP_UNUSED, '1, '1);
    fill_frame(1'b0);
    send_req(OP_WRITE, '0, '0);
    send_req(OP_WRITE, 6'(PIXEL_COUNT - 1), '1);
    send_req(OP_WRITE, 6'd21, RED_MASK);
    send_req(OP_WRITE, 6'd42, GREEN_MASK);
    send_req(OP_WRITE, 6'd7, BLUE_MASK);

    // zero counts stretch to one tick
    set_timing('0, '0, '0, '0, '0);
    run_frame(40, 600, 1200, 2200);
    random_round();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
